// File: design/ims_pkg.sv
// Shared types and widths for the interval merge sorter.
`default_nettype none
package ims_pkg;

  localparam int START_W = 31;
  localparam int LEN_W   = 31;
  localparam int END_W   = 32;

  typedef struct packed {
    logic               vld;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shf;
  } cell_ctl_t;

  typedef struct packed {
    logic draining;
    logic shf;
  } merge_stat_t;

endpackage
`default_nettype wire

// File: design/ims_cell.sv
// One slot of the sorted interval chain: sorted insert and shift toward the head.
`default_nettype none
module ims_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ims_pkg::cell_ctl_t ctl,
  input  wire ims_pkg::entry_t    new_ent,
  input  wire ims_pkg::entry_t    prev_ent,
  input  wire logic               prev_pass,
  input  wire ims_pkg::entry_t    next_ent,
  output ims_pkg::entry_t         ent,
  output logic                    pass
);

  logic                        vld_r;
  logic [ims_pkg::START_W-1:0] start_r;
  logic [ims_pkg::LEN_W-1:0]   len_r;
  ims_pkg::entry_t             ent_nxt;

  assign ent.vld   = vld_r;
  assign ent.start = start_r;
  assign ent.len   = len_r;

  always_comb begin
    pass    = vld_r && (start_r < new_ent.start);
    ent_nxt = ent;
    priority if (ctl.shf) begin
      ent_nxt = next_ent;
    end else if (ctl.ins && !pass) begin
      ent_nxt = prev_pass ? new_ent : prev_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ent_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= ent_nxt.start;
    len_r   <= ent_nxt.len;
  end

endmodule
`default_nettype wire

// File: design/ims_merge.sv
// Merge unit at the chain head: folds sorted intervals and drives the result register.
`default_nettype none
module ims_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start_drain,
  input  wire logic                        drop,
  input  wire ims_pkg::entry_t             head,
  output ims_pkg::merge_stat_t             stat,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ims_pkg::START_W-1:0]      out_merged_start,
  output logic [ims_pkg::END_W-1:0]        out_merged_length,
  output logic                             out_last_result,
  output logic                             out_overflowed
);

  logic                        drain_r, drain_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        cur_vld_r, cur_vld_nxt;
  logic [ims_pkg::START_W-1:0] cur_start_r, cur_start_nxt;
  logic [ims_pkg::END_W-1:0]   cur_end_r, cur_end_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ims_pkg::START_W-1:0] out_start_r;
  logic [ims_pkg::END_W-1:0]   out_len_r;
  logic                        out_last_r, out_ovf_r;
  logic [ims_pkg::END_W-1:0]   head_end;
  logic                        ovl, out_free, emit, emit_last, shf;

  always_comb begin
    head_end    = {1'b0, head.start} + {1'b0, head.len};
    ovl         = cur_end_r >= {1'b0, head.start};
    out_free    = !out_valid_r || !out_stall;
    drain_nxt   = drain_r;
    ovf_nxt     = ovf_r | drop;
    cur_vld_nxt = cur_vld_r;
    cur_start_nxt = cur_start_r;
    cur_end_nxt = cur_end_r;
    emit        = 1'b0;
    emit_last   = 1'b0;
    shf         = 1'b0;
    if (drain_r) begin
      priority if (head.vld && !cur_vld_r) begin
        cur_vld_nxt   = 1'b1;
        cur_start_nxt = head.start;
        cur_end_nxt   = head_end;
        shf           = 1'b1;
      end else if (head.vld && ovl) begin
        if (head_end > cur_end_r) begin
          cur_end_nxt = head_end;
        end
        shf = 1'b1;
      end else if (head.vld) begin
        if (out_free) begin
          emit          = 1'b1;
          cur_start_nxt = head.start;
          cur_end_nxt   = head_end;
          shf           = 1'b1;
        end
      end else if (cur_vld_r) begin
        if (out_free) begin
          emit        = 1'b1;
          emit_last   = 1'b1;
          cur_vld_nxt = 1'b0;
          drain_nxt   = 1'b0;
          ovf_nxt     = 1'b0;
        end
      end else begin
        drain_nxt = 1'b0;
        ovf_nxt   = 1'b0;
      end
    end else if (start_drain) begin
      drain_nxt = 1'b1;
    end
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r     <= 1'b0;
      ovf_r       <= 1'b0;
      cur_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      drain_r     <= drain_nxt;
      ovf_r       <= ovf_nxt;
      cur_vld_r   <= cur_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_start_r <= cur_start_nxt;
    cur_end_r   <= cur_end_nxt;
    if (emit) begin
      out_start_r <= cur_start_r;
      out_len_r   <= cur_end_r - {1'b0, cur_start_r};
      out_last_r  <= emit_last;
      out_ovf_r   <= ovf_r;
    end
  end

  assign stat.draining     = drain_r;
  assign stat.shf          = shf;
  assign out_valid         = out_valid_r;
  assign out_merged_start  = out_start_r;
  assign out_merged_length = out_len_r;
  assign out_last_result   = out_last_r;
  assign out_overflowed    = out_ovf_r;

endmodule
`default_nettype wire

// File: design/interval_merge_sorter.sv
// Top level: sorted chain of interval cells feeding a merge unit at its head.
// A non-final beat is stored in the chain unless it is full; one interval is accepted per cycle while in_stall is low.
// A final beat starts a drain that shifts the chain through the merge unit one
// entry per cycle unless a finished result waits on out_stall; in_stall is high
// for the whole drain.
// Reset (rst_n low, synchronous) empties the chain and clears the overflow flag.
`default_nettype none
module interval_merge_sorter #(
  parameter int CAPACITY = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ims_pkg::START_W-1:0] in_start_req,
  input  wire logic [ims_pkg::LEN_W-1:0]   in_length,
  input  wire logic                        in_final_item,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ims_pkg::START_W-1:0]      out_merged_start,
  output logic [ims_pkg::END_W-1:0]        out_merged_length,
  output logic                             out_last_result,
  output logic                             out_overflowed
);

  ims_pkg::entry_t      ent [CAPACITY];
  logic                 pass [CAPACITY];
  ims_pkg::entry_t      new_ent;
  ims_pkg::entry_t      empty_ent;
  ims_pkg::cell_ctl_t   ctl;
  ims_pkg::merge_stat_t stat;
  logic                 acc, full;

  assign in_stall  = stat.draining;
  assign acc       = in_valid && !in_stall;
  assign full      = ent[CAPACITY-1].vld;
  assign ctl.ins   = acc && !full;
  assign ctl.shf   = stat.shf;

  assign new_ent.vld   = 1'b1;
  assign new_ent.start = in_start_req;
  assign new_ent.len   = in_length;

  assign empty_ent = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ims_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_ent   (new_ent),
      .prev_ent  ((i == 0) ? empty_ent : ent[(i == 0) ? 0 : i-1]),
      .prev_pass ((i == 0) ? 1'b1 : pass[(i == 0) ? 0 : i-1]),
      .next_ent  ((i == CAPACITY-1) ? empty_ent : ent[(i == CAPACITY-1) ? i : i+1]),
      .ent       (ent[i]),
      .pass      (pass[i])
    );
  end

  ims_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .start_drain       (acc && in_final_item),
    .drop              (acc && full),
    .head              (ent[0]),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_merged_start  (out_merged_start),
    .out_merged_length (out_merged_length),
    .out_last_result   (out_last_result),
    .out_overflowed    (out_overflowed)
  );

  for (genvar i = 1; i < CAPACITY; i++) begin : g_chk
    a_contig: assert property (@(posedge clk) disable iff (!rst_n)
      ent[i].vld |-> ent[i-1].vld)
      else $error("chain entries not contiguous");
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_merged_start)
      && $stable(out_merged_length) && $stable(out_last_result)
      && $stable(out_overflowed)))
    else $error("result changed while stalled");

  a_empty_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(stat.draining) |-> !ent[0].vld)
    else $error("chain not empty after drain");

  a_no_shift_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.shf |-> (stat.draining && ent[0].vld))
    else $error("shift outside drain");

endmodule
`default_nettype wire
